/* rtl/core/ryb_hue_table_warp_defines.svh */
// Assertion macros for the RYB hue warp block.
// Used by the controller; the macros expect clk and rst_n in scope.
`ifndef RYB_HUE_TABLE_WARP_DEFINES_SVH
`define RYB_HUE_TABLE_WARP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define RYBW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rybw assertion failed");
`define RYBW_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rybw assertion failed");
`else
`define RYBW_ASSERT(lbl, prop)
`define RYBW_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* rtl/core/rybw_pkg.sv */
// Shared types, constants and the warp table for the RYB hue warp block.
// No dependencies.
`default_nettype none

package rybw_pkg;

  localparam int HUE_IN_W           = 16;
  localparam int HUE_OUT_W          = 17;
  localparam int DEF_TABLE_SEGMENTS = 36;
  localparam int DEF_HUE_BITS       = 16;

  localparam int ROM_POINTS = 37;
  localparam longint unsigned ROM_UNIT = 64'd100000000;

  // table points in units of 1e-8 turn
  localparam int unsigned WARP_ROM [ROM_POINTS] = '{
    0,        2156867,  4248367,  6405234,  7385617,  8431367,
    9411767,  10653600, 11830067, 13071899, 14248367, 15490200,
    16666667, 18354435, 19954120, 21666662, 25130904, 28545108,
    31976745, 38981494, 46010628, 53061217, 54649121, 56159425,
    57771534, 60190469, 62573093, 64980155, 68875504, 72801632,
    76708061, 80924863, 85215056, 89478123, 92933953, 96468931,
    100000000
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FSEG,
    ST_FLOOK,
    ST_FMAC,
    ST_SCAN,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic seg;
    logic look;
    logic mac;
    logic scan;
    logic miss;
    logic prep;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic scan_last;
  } sts_t;

  // table point k scaled to Q1.hb, round half up (elaboration only)
  function automatic longint unsigned rom_scale(input int k, input int hb);
    return ((longint'(WARP_ROM[k]) << hb) + ROM_UNIT / 2) / ROM_UNIT;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/ryb_hue_table_warp.sv */
// Top level of the RYB hue warp: controller plus datapath.
// Depends on rybw_pkg, rybw_ctrl and rybw_dp.
//
//   channel | ports                                  | direction
//   input   | in_valid, in_stall, in_hue_in, in_action | into block
//   result  | out_valid, out_stall, out_hue_out        | out of block
//
// Forward warp: multiply, lookup, interpolate, then output. Inverse warp: a serial
// scan over up to TABLE_SEGMENTS table segments, then, if a segment is found, a
// restoring divide that yields HUE_BITS+1 quotient bits.
// Reset is synchronous, active low; no clearing pass is needed.
// A finished result waits in the output register while the next transaction
// is taken; a stalled output only holds the block at its final step.
`default_nettype none

module ryb_hue_table_warp #(
  parameter int TABLE_SEGMENTS = rybw_pkg::DEF_TABLE_SEGMENTS,
  parameter int HUE_BITS       = rybw_pkg::DEF_HUE_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [rybw_pkg::HUE_IN_W-1:0]  in_hue_in,
  input  wire logic                           in_action,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [rybw_pkg::HUE_OUT_W-1:0] out_hue_out
);
  import rybw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rybw_ctrl #(
    .HUE_BITS (HUE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  rybw_dp #(
    .TABLE_SEGMENTS (TABLE_SEGMENTS),
    .HUE_BITS       (HUE_BITS)
  ) u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .sts     (sts),
    .hue_in  (in_hue_in),
    .hue_out (out_hue_out)
  );

endmodule

`default_nettype wire

/* rtl/core/rybw_dp.sv */
// Datapath of the RYB hue warp: table lookup, interpolation, scan and
// restoring divider. Depends on rybw_pkg.
`default_nettype none

module rybw_dp #(
  parameter int TABLE_SEGMENTS = rybw_pkg::DEF_TABLE_SEGMENTS,
  parameter int HUE_BITS       = rybw_pkg::DEF_HUE_BITS
) (
  input  wire logic                           clk,
  input  wire rybw_pkg::cmd_t                 cmd,
  output rybw_pkg::sts_t                      sts,
  input  wire logic [rybw_pkg::HUE_IN_W-1:0]  hue_in,
  output logic      [rybw_pkg::HUE_OUT_W-1:0] hue_out
);
  import rybw_pkg::*;

  localparam int HB  = HUE_BITS;
  localparam int TS  = TABLE_SEGMENTS;
  localparam int IW  = $clog2(TS);
  localparam int EW  = HB + 1;
  localparam int TW  = $clog2(ROM_POINTS);
  localparam int TSW = $clog2(TS + 1);
  localparam int PW  = HB + TSW;
  localparam int DW  = EW + TSW;
  localparam int RW  = DW + 1;
  localparam int MW  = EW + HB;

  logic [EW-1:0] ent [ROM_POINTS];

  for (genvar g = 0; g < ROM_POINTS; g++) begin : g_rom
    assign ent[g] = EW'(rom_scale(g, HB));
  end

  logic [HB-1:0] h_r,    h_nxt;
  logic [IW-1:0] i_r,    i_nxt;
  logic [HB-1:0] frac_r, frac_nxt;
  logic [EW-1:0] lo_r,   lo_nxt;
  logic [EW-1:0] d_r,    d_nxt;
  logic [EW-1:0] r_r,    r_nxt;
  logic [RW-1:0] rem_r,  rem_nxt;
  logic [DW-1:0] div_r,  div_nxt;
  logic [EW-1:0] q_r,    q_nxt;
  logic [HUE_OUT_W-1:0] out_r, out_nxt;

  logic [PW-1:0] prod_seg;
  logic [IW:0]   k_lo, k_hi;
  logic [TW-1:0] idx_lo, idx_hi;
  logic [EW-1:0] lo, hi, d, r_raw, r_clamp, h_ext;
  logic [MW-1:0] prod_mac;
  logic [EW-1:0] mac;
  logic [DW-1:0] a_mul, a_val, d_mul, d_val;
  logic          ge;
  logic [RW-1:0] rem_sub;

  // segment lookup shared by forward and scan
  assign k_lo   = {1'b0, i_r};
  assign k_hi   = k_lo + 1'b1;
  assign idx_lo = (32'(k_lo) >= ROM_POINTS) ? TW'(ROM_POINTS - 1) : TW'(k_lo);
  assign idx_hi = (32'(k_hi) >= ROM_POINTS) ? TW'(ROM_POINTS - 1) : TW'(k_hi);
  assign lo     = ent[idx_lo];
  assign hi     = ent[idx_hi];
  assign d      = (hi >= lo) ? hi - lo : '0;
  assign h_ext  = {1'b0, h_r};
  assign r_raw  = (h_ext >= lo) ? h_ext - lo : '0;
  assign r_clamp = (r_raw > d) ? d : r_raw;

  assign prod_seg = PW'(h_r) * PW'(TS);
  assign prod_mac = MW'(d_r) * MW'(frac_r);
  assign mac      = lo_r + EW'(prod_mac >> HB);

  assign a_mul = DW'(i_r) * DW'(d_r);
  assign d_mul = DW'(d_r) * DW'(TS);
  // flat segment: quotient i/TS through the same divider
  assign a_val = (d_r == '0) ? DW'(i_r) : a_mul + DW'(r_r);
  assign d_val = (d_r == '0) ? DW'(TS) : d_mul;

  assign ge      = rem_r >= RW'(div_r);
  assign rem_sub = ge ? rem_r - RW'(div_r) : rem_r;

  always_comb begin
    h_nxt    = h_r;
    i_nxt    = i_r;
    frac_nxt = frac_r;
    lo_nxt   = lo_r;
    d_nxt    = d_r;
    r_nxt    = r_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    q_nxt    = q_r;
    out_nxt  = out_r;
    if (cmd.load) begin
      h_nxt = HB'(hue_in);
      i_nxt = '0;
    end
    if (cmd.seg) begin
      i_nxt    = IW'(prod_seg >> HB);
      frac_nxt = prod_seg[HB-1:0];
    end
    if (cmd.look) begin
      lo_nxt = lo;
      d_nxt  = d;
    end
    if (cmd.mac) begin
      q_nxt = mac;
    end
    if (cmd.scan) begin
      if (sts.found) begin
        lo_nxt = lo;
        d_nxt  = d;
        r_nxt  = r_clamp;
      end else begin
        i_nxt = i_r + 1'b1;
      end
    end
    if (cmd.miss) begin
      q_nxt = {1'b1, {HB{1'b0}}};
    end
    if (cmd.prep) begin
      rem_nxt = RW'(a_val);
      div_nxt = d_val;
      q_nxt   = '0;
    end
    if (cmd.step) begin
      rem_nxt = rem_sub << 1;
      q_nxt   = {q_r[EW-2:0], ge};
    end
    if (cmd.emit) begin
      out_nxt = HUE_OUT_W'(q_r);
    end
  end

  always_ff @(posedge clk) begin
    h_r    <= h_nxt;
    i_r    <= i_nxt;
    frac_r <= frac_nxt;
    lo_r   <= lo_nxt;
    d_r    <= d_nxt;
    r_r    <= r_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    q_r    <= q_nxt;
    out_r  <= out_nxt;
  end

  assign sts.found     = hi >= h_ext;
  assign sts.scan_last = (i_r == IW'(TS - 1));
  assign hue_out       = out_r;

endmodule

`default_nettype wire

/* rtl/core/rybw_ctrl.sv */
// Controller of the RYB hue warp: sequences forward and inverse warps and
// owns the handshakes. Depends on rybw_pkg and the assertion macro header.
`default_nettype none
`include "ryb_hue_table_warp_defines.svh"

module rybw_ctrl #(
  parameter int HUE_BITS = rybw_pkg::DEF_HUE_BITS
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire logic           in_action,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  output rybw_pkg::cmd_t      cmd,
  input  wire rybw_pkg::sts_t sts
);
  import rybw_pkg::*;

  localparam int CW = $clog2(HUE_BITS + 1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          div_last;

  assign div_last = (cnt_r == CW'(HUE_BITS));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_action ? ST_FSEG : ST_SCAN;
        end
      end
      ST_FSEG:  state_nxt = ST_FLOOK;
      ST_FLOOK: state_nxt = ST_FMAC;
      ST_FMAC:  state_nxt = ST_DONE;
      ST_SCAN: begin
        if (sts.found) begin
          state_nxt = ST_PREP;
        end else if (sts.scan_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_PREP: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE:  cmd.load = in_valid;
      ST_FSEG:  cmd.seg  = 1'b1;
      ST_FLOOK: cmd.look = 1'b1;
      ST_FMAC:  cmd.mac  = 1'b1;
      ST_SCAN: begin
        cmd.scan = 1'b1;
        cmd.miss = !sts.found && sts.scan_last;
      end
      ST_PREP:  cmd.prep = 1'b1;
      ST_DIV:   cmd.step = 1'b1;
      ST_DONE:  cmd.emit = !out_valid_r || !out_stall;
      default:  cmd = '0;
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.prep) begin
      cnt_nxt = '0;
    end else if (cmd.step) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  `RYBW_ASSERT(a_no_overwrite, cmd.emit |-> !(out_valid_r && out_stall))
  `RYBW_ASSERT(a_div_len, (state_r == ST_DIV && div_last) |=> (state_r == ST_DONE))
  `RYBW_ASSERT(a_out_drop, $fell(out_valid_r) |-> $past(!out_stall))
  `RYBW_ASSERT(a_accept_path,
    (in_valid && !in_stall) |=> (state_r == ST_FSEG || state_r == ST_SCAN))

endmodule

`default_nettype wire

/* test/tb_ryb_hue_table_warp.sv */
// Self-checking testbench for ryb_hue_table_warp: forward and inverse table warps,
// predicted in-bench from the ROM points in rybw_pkg, with random idling on both sides.
// Depends on rybw_pkg and the RTL of ryb_hue_table_warp.
`default_nettype none

module tb_ryb_hue_table_warp;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  SEGS        = rybw_pkg::DEF_TABLE_SEGMENTS;
  localparam int  HB          = rybw_pkg::DEF_HUE_BITS;
  localparam longint unsigned FULL_TURN = longint'(1) << HB;
  localparam logic ACT_INVERSE = 1'b0;
  localparam logic ACT_FORWARD = 1'b1;
  localparam int  CYCLE_LIMIT = 600000;
  localparam int  DRAIN_CYCLES = 80;

  typedef struct {
    logic [rybw_pkg::HUE_IN_W-1:0]  hue;
    logic                           act;
    logic [rybw_pkg::HUE_OUT_W-1:0] warped;
  } warp_exp_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [rybw_pkg::HUE_IN_W-1:0]  in_hue_in = '0;
  logic                           in_action = ACT_FORWARD;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [rybw_pkg::HUE_OUT_W-1:0] out_hue_out;

  warp_exp_t expected_warps[$];
  int        errors = 0;
  int        cycle_count = 0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;

  ryb_hue_table_warp dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_hue_in  (in_hue_in),
    .in_action  (in_action),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_hue_out(out_hue_out)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ROM point k in Q1.HB, nearest with ties up; index saturates at the last point
  function automatic longint unsigned table_point(input longint unsigned k);
    longint unsigned v;
    longint unsigned idx;
    idx = (k >= rybw_pkg::ROM_POINTS) ? rybw_pkg::ROM_POINTS - 1 : k;
    v = rybw_pkg::WARP_ROM[idx];
    v = ((v << HB) + rybw_pkg::ROM_UNIT / 2) / rybw_pkg::ROM_UNIT;
    return v;
  endfunction

  function automatic longint unsigned warp_fwd(input longint unsigned h);
    longint unsigned p, seg, frac, lo, hi, d;
    p    = h * SEGS;
    seg  = p >> HB;
    frac = p & (FULL_TURN - 1);
    lo   = table_point(seg);
    hi   = table_point(seg + 1);
    d    = (hi >= lo) ? hi - lo : 0;
    return lo + ((d * frac) >> HB);
  endfunction

  function automatic longint unsigned warp_inv(input longint unsigned h);
    longint unsigned lo, hi, d, r;
    for (longint unsigned i = 0; i < SEGS; i++) begin
      lo = table_point(i);
      hi = table_point(i + 1);
      if (hi >= h) begin
        d = (hi >= lo) ? hi - lo : 0;
        r = (h >= lo) ? h - lo : 0;
        if (d == 0) return (i << HB) / SEGS;
        if (r > d) r = d;
        return ((i * d + r) << HB) / (d * SEGS);
      end
    end
    return FULL_TURN;
  endfunction

  function automatic logic [rybw_pkg::HUE_OUT_W-1:0] predict_warp(
      input logic [rybw_pkg::HUE_IN_W-1:0] hue, input logic act);
    longint unsigned h, w;
    h = hue & (FULL_TURN - 1);
    w = (act == ACT_FORWARD) ? warp_fwd(h) : warp_inv(h);
    if (w > FULL_TURN) w = FULL_TURN;
    return w[rybw_pkg::HUE_OUT_W-1:0];
  endfunction

  // called just after a rising edge; returns just after the accepting edge, valid left high
  task automatic send_hue(input logic [rybw_pkg::HUE_IN_W-1:0] hue, input logic act);
    warp_exp_t e;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid  <= 1'b0;
      in_hue_in <= 16'($urandom);
      in_action <= 1'($urandom);
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_hue_in <= hue;
    in_action <= act;
    do @(posedge clk); while (in_stall);
    e.hue    = hue;
    e.act    = act;
    e.warped = predict_warp(hue, act);
    expected_warps.insert(expected_warps.size(), e);
  endtask

  task automatic test_extremes();
    send_hue('0, ACT_FORWARD);
    send_hue('0, ACT_INVERSE);
    send_hue('1, ACT_FORWARD);
    send_hue('1, ACT_INVERSE);
  endtask

  // inverse scan right at, below and above a table point
  task automatic test_table_edges();
    int pts[4] = '{1, 12, 21, 35};
    longint unsigned e;
    foreach (pts[j]) begin
      e = table_point(64'(pts[j]));
      send_hue(e[15:0], ACT_INVERSE);
      send_hue(e[15:0] - 16'd1, ACT_INVERSE);
      send_hue(e[15:0] + 16'd1, ACT_INVERSE);
    end
  endtask

  // forward warp on either side of a segment boundary
  task automatic test_segment_edges();
    int segs[3] = '{1, 18, 35};
    longint unsigned b;
    foreach (segs[j]) begin
      b = (longint'(segs[j]) * FULL_TURN + SEGS - 1) / SEGS;
      send_hue(b[15:0], ACT_FORWARD);
      send_hue(b[15:0] - 16'd1, ACT_FORWARD);
    end
  endtask

  task automatic test_random(input int n);
    longint unsigned b;
    logic act;
    logic [15:0] hue;
    repeat (n) begin
      act = 1'($urandom);
      hue = 16'($urandom);
      if ($urandom_range(99) < 25) begin
        if (act == ACT_INVERSE) b = table_point(64'($urandom_range(1, SEGS - 1)));
        else b = (longint'($urandom_range(1, SEGS - 1)) * FULL_TURN + SEGS - 1) / SEGS;
        hue = b[15:0] + 16'($urandom_range(2)) - 16'd1;
      end
      send_hue(hue, act);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk) begin : check_warp
    warp_exp_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_warps.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual hue_out %0d",
                 $time, out_hue_out);
        errors++;
      end else begin
        e = expected_warps.pop_front();
        if (out_hue_out !== e.warped) begin
          $display("%0t: hue_in %0d action %0b: expected hue_out %0d, actual %0d",
                   $time, e.hue, e.act, e.warped, out_hue_out);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 37;
    rx_idle_pct = 55;
    test_extremes();
    test_table_edges();
    test_segment_edges();
    test_random(510);

    tx_idle_pct = 55;
    rx_idle_pct = 37;
    test_random(510);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random(510);
    in_valid <= 1'b0;

    while (expected_warps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
+incdir+rtl/core
rtl/core/rybw_pkg.sv
rtl/core/rybw_dp.sv
rtl/core/rybw_ctrl.sv
rtl/core/ryb_hue_table_warp.sv
test/tb_ryb_hue_table_warp.sv
